// File: hdl/pmct_pkg.sv
// Package for the PS/2 mouse packet cursor tracker.
// Holds the packet type, byte phase states, register indexes and constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pmct_pkg;

	localparam int LIMIT_W = 12;
	localparam int BYTE_W  = 8;
	localparam int BTN_W   = 3;
	localparam int Q_DEPTH = 2;

	localparam int SIGN_X_POS = 4;
	localparam int SIGN_Y_POS = 5;

	localparam logic [LIMIT_W-1:0] X_LIMIT_RESET = 12'd319;
	localparam logic [LIMIT_W-1:0] Y_LIMIT_RESET = 12'd199;
	localparam logic [LIMIT_W-1:0] POS_X_RESET   = 12'd160;
	localparam logic [LIMIT_W-1:0] POS_Y_RESET   = 12'd100;

	localparam logic REG_X_LIMIT = 1'b0;
	localparam logic REG_Y_LIMIT = 1'b1;

	typedef enum logic [1:0] {
		PH_HEAD = 2'd0,
		PH_XD   = 2'd1,
		PH_YD   = 2'd2
	} phase_t;

	typedef struct packed {
		logic [BTN_W-1:0]  buttons;
		logic              x_sign;
		logic              y_sign;
		logic [BYTE_W-1:0] x_mag;
		logic [BYTE_W-1:0] y_mag;
	} packet_t;

endpackage

`default_nettype wire

// File: hdl/ps2_mouse_packet_cursor_tracker.sv
// Top level of the PS/2 mouse packet cursor tracker.
// Instantiates pmct_front, pmct_queue and pmct_back; holds the limit registers.
// Depends on pmct_pkg.
//
//   channel   signals                                   direction
//   byte      byte_valid, byte_stall, data_byte         in
//   result    result_valid, result_stall, cursor_x/y,   out
//             button_bits
//   config    cfg_we, cfg_index, cfg_data               in
//
// One byte accepted per cycle; byte_stall rises only while the two-entry
// packet queue is full. A packet whose third byte is accepted is queued,
// then registered as the result, which is held until taken. Reset puts the
// cursor at 160,100, the limits at 319,199 and expects a header byte next.
`timescale 1ns / 1ps
`default_nettype none

module ps2_mouse_packet_cursor_tracker #(
	parameter int COORD_BITS = 12
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              byte_valid,
	output logic                             byte_stall,
	input  wire  [pmct_pkg::BYTE_W-1:0]      data_byte,
	output logic                             result_valid,
	input  wire                              result_stall,
	output logic [pmct_pkg::LIMIT_W-1:0]     cursor_x,
	output logic [pmct_pkg::LIMIT_W-1:0]     cursor_y,
	output logic [pmct_pkg::BTN_W-1:0]       button_bits,
	input  wire                              cfg_we,
	input  wire                              cfg_index,
	input  wire  [pmct_pkg::LIMIT_W-1:0]     cfg_data
);

	logic [pmct_pkg::LIMIT_W-1:0] x_limit_q, y_limit_q;
	logic push, pop, q_full, q_valid;
	pmct_pkg::packet_t push_pkt, pop_pkt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_limit_q <= pmct_pkg::X_LIMIT_RESET;
			y_limit_q <= pmct_pkg::Y_LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pmct_pkg::REG_X_LIMIT: x_limit_q <= cfg_data;
				pmct_pkg::REG_Y_LIMIT: y_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pmct_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.data_byte  (data_byte),
		.q_full     (q_full),
		.push       (push),
		.push_pkt   (push_pkt)
	);

	pmct_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_pkt (push_pkt),
		.full     (q_full),
		.pop      (pop),
		.q_valid  (q_valid),
		.pop_pkt  (pop_pkt)
	);

	pmct_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.pop_pkt      (pop_pkt),
		.pop          (pop),
		.x_limit      (x_limit_q),
		.y_limit      (y_limit_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cursor_x     (cursor_x),
		.cursor_y     (cursor_y),
		.button_bits  (button_bits)
	);

endmodule

`default_nettype wire

// File: hdl/pmct_front.sv
// Front end: assembles received bytes into three-byte packets.
// Pushes one packet_t per completed packet into the queue.
// Depends on pmct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pmct_front (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              byte_valid,
	output logic                             byte_stall,
	input  wire  [pmct_pkg::BYTE_W-1:0]      data_byte,
	input  wire                              q_full,
	output logic                             push,
	output pmct_pkg::packet_t                push_pkt
);

	pmct_pkg::phase_t phase_q, phase_nxt;
	logic [pmct_pkg::BYTE_W-1:0] header_q;
	logic [pmct_pkg::BYTE_W-1:0] xdelta_q;
	logic take;

	assign byte_stall = q_full;
	assign take       = byte_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pmct_pkg::PH_HEAD;
		end else begin
			phase_q <= phase_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (take && phase_q == pmct_pkg::PH_XD) begin
			xdelta_q <= data_byte;
		end
		if (take && phase_q != pmct_pkg::PH_XD && phase_q != pmct_pkg::PH_YD) begin
			header_q <= data_byte;
		end
	end

	always_comb begin
		phase_nxt = phase_q;
		push      = 1'b0;
		case (phase_q)
			pmct_pkg::PH_HEAD: begin
				if (take) phase_nxt = pmct_pkg::PH_XD;
			end
			pmct_pkg::PH_XD: begin
				if (take) phase_nxt = pmct_pkg::PH_YD;
			end
			pmct_pkg::PH_YD: begin
				if (take) begin
					phase_nxt = pmct_pkg::PH_HEAD;
					push      = 1'b1;
				end
			end
			default: begin
				// stray phase acts as header phase
				if (take) phase_nxt = pmct_pkg::PH_XD;
			end
		endcase
	end

	assign push_pkt.buttons = header_q[pmct_pkg::BTN_W-1:0];
	assign push_pkt.x_sign  = header_q[pmct_pkg::SIGN_X_POS];
	assign push_pkt.y_sign  = header_q[pmct_pkg::SIGN_Y_POS];
	assign push_pkt.x_mag   = xdelta_q;
	assign push_pkt.y_mag   = data_byte;

	a_push_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> phase_q == pmct_pkg::PH_HEAD)
		else $error("phase did not return to header after a packet");

endmodule

`default_nettype wire

// File: hdl/pmct_queue.sv
// Two-entry packet queue between the front end and the cursor update.
// Depends on pmct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pmct_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  wire pmct_pkg::packet_t push_pkt,
	output logic               full,
	input  wire                pop,
	output logic               q_valid,
	output pmct_pkg::packet_t  pop_pkt
);

	localparam int PTR_W = $clog2(pmct_pkg::Q_DEPTH);
	localparam int CNT_W = $clog2(pmct_pkg::Q_DEPTH + 1);

	pmct_pkg::packet_t mem_q [pmct_pkg::Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = count_q == CNT_W'(pmct_pkg::Q_DEPTH);
	assign q_valid = count_q != '0;
	assign pop_pkt = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_pkt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && count_q == '0))
		else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: hdl/pmct_back.sv
// Back end: applies a packet to the cursor and clamps each axis.
// Position registers double as the result register.
// Depends on pmct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pmct_back #(
	parameter int COORD_BITS = 12
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               q_valid,
	input  wire pmct_pkg::packet_t            pop_pkt,
	output logic                              pop,
	input  wire  [pmct_pkg::LIMIT_W-1:0]      x_limit,
	input  wire  [pmct_pkg::LIMIT_W-1:0]      y_limit,
	output logic                              result_valid,
	input  wire                               result_stall,
	output logic [pmct_pkg::LIMIT_W-1:0]      cursor_x,
	output logic [pmct_pkg::LIMIT_W-1:0]      cursor_y,
	output logic [pmct_pkg::BTN_W-1:0]        button_bits
);

	localparam int LW    = pmct_pkg::LIMIT_W;
	localparam int POS_W = (COORD_BITS < LW) ? COORD_BITS : LW;
	localparam int SUM_W = POS_W + 2;
	localparam logic [LW-1:0] CEIL = (COORD_BITS >= LW) ? {LW{1'b1}} :
		LW'((1 << COORD_BITS) - 1);

	function automatic logic [POS_W-1:0] clamp(input logic [SUM_W-1:0] v,
			input logic [POS_W-1:0] top);
		if (v[SUM_W-1]) return '0;
		if (v[SUM_W-2:0] > {1'b0, top}) return top;
		return v[POS_W-1:0];
	endfunction

	logic [POS_W-1:0] pos_x_q, pos_y_q;
	logic [pmct_pkg::BTN_W-1:0] buttons_q;
	logic result_valid_q;
	logic [LW-1:0] top_x, top_y;
	logic [SUM_W-1:0] dx, dy, sum_x, sum_y;

	assign top_x = (x_limit > CEIL) ? CEIL : x_limit;
	assign top_y = (y_limit > CEIL) ? CEIL : y_limit;

	assign dx = {{(SUM_W-9){pop_pkt.x_sign}}, pop_pkt.x_sign, pop_pkt.x_mag};
	assign dy = {{(SUM_W-9){pop_pkt.y_sign}}, pop_pkt.y_sign, pop_pkt.y_mag};
	assign sum_x = {2'b00, pos_x_q} + dx;
	assign sum_y = {2'b00, pos_y_q} - dy;

	assign pop = q_valid && (!result_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q        <= POS_W'(pmct_pkg::POS_X_RESET);
			pos_y_q        <= POS_W'(pmct_pkg::POS_Y_RESET);
			buttons_q      <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				pos_x_q        <= clamp(sum_x, top_x[POS_W-1:0]);
				pos_y_q        <= clamp(sum_y, top_y[POS_W-1:0]);
				buttons_q      <= pop_pkt.buttons;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign cursor_x     = LW'(pos_x_q);
	assign cursor_y     = LW'(pos_y_q);
	assign button_bits  = buttons_q;

	a_pop_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> result_valid_q)
		else $error("popped packet produced no result");

	a_taken_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && !result_stall && !q_valid) |=> !result_valid_q)
		else $error("result repeated after being taken");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_x <= CEIL && cursor_y <= CEIL)
		else $error("cursor beyond coordinate range");

endmodule

`default_nettype wire
